FILE: rtl/ils_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types of the item list sequencer.
package ils_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int VALUE_BITS  = 32;
  localparam int RAND_BITS   = 16;
  localparam int SLOT_BITS   = $clog2(TABLE_DEPTH);
  localparam int COUNT_BITS  = $clog2(TABLE_DEPTH + 1);
  localparam int MODE_BITS   = 2;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_DRAW  = 1'b1;

  localparam logic REG_WALK_MODE   = 1'b0;
  localparam logic REG_ENTRY_COUNT = 1'b1;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_CYCLE  = 2'd0,
    MODE_SWING  = 2'd1,
    MODE_RANDOM = 2'd2,
    MODE_HEAP   = 2'd3
  } walk_mode_t;

  typedef struct packed {
    walk_mode_t             mode;
    logic [COUNT_BITS-1:0]  count;
  } walk_cfg_t;

  typedef struct packed {
    logic                  fire;
    logic [SLOT_BITS-1:0]  slot;
  } pick_t;

endpackage

FILE: rtl/item_list_sequencer.sv
`timescale 1ns / 1ps
// Top level of the item list sequencer.
//
// Usage:
//   The command channel (cmd_valid/cmd_ready) carries one transaction per
//   item: a write stores entry_value at entry_index of the value table and
//   gives no result; a draw picks one slot by walk_mode and returns its
//   value and slot on the item channel (item_valid/item_ready). A heap draw
//   that lands on an already used slot gives no result.
//   A result appears in the cycle after its draw is accepted, read from the
//   registered port of the value table, which also serves as the output
//   register. Throughput: one command per cycle while the receiver takes
//   each result. While a result waits unaccepted, cmd_ready is low and the
//   command side holds; accepting the result and the next command in one
//   cycle is fine. Reset clears pointer and use marks, sets direction up,
//   walk_mode (cycle) and entry_count to 1; table contents are undefined
//   until written. cfg_we writes walk_mode (index 0) or entry_count
//   (index 1); the user must do so only while idle, unchecked by the block.
module item_list_sequencer
  import ils_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [COUNT_BITS-1:0] cfg_data,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  logic                  command,
  input  logic [5:0]            entry_index,
  input  logic [31:0]           entry_value,
  input  logic [15:0]           rand_frac,
  output logic                  item_valid,
  input  logic                  item_ready,
  output logic [31:0]           item_value,
  output logic [5:0]            item_slot
);

  walk_mode_t            walk_mode;
  logic [COUNT_BITS-1:0] entry_count;
  walk_cfg_t             cfg;
  pick_t                 pick;
  logic                  accept;
  logic                  draw;
  logic                  write;
  logic [SLOT_BITS-1:0]  slot_q;
  logic [VALUE_BITS-1:0] rd_data;

  assign cmd_ready = !item_valid || item_ready;
  assign accept    = cmd_valid && cmd_ready;
  assign draw      = accept && (command == CMD_DRAW);
  assign write     = accept && (command == CMD_WRITE);
  assign cfg.mode  = walk_mode;
  assign cfg.count = entry_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_mode   <= MODE_CYCLE;
      entry_count <= COUNT_BITS'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WALK_MODE:   walk_mode   <= walk_mode_t'(cfg_data[MODE_BITS-1:0]);
        REG_ENTRY_COUNT: entry_count <= cfg_data;
        default:         entry_count <= entry_count;
      endcase
    end
  end

  ils_walker u_walker (
    .clk  (clk),
    .rst  (rst),
    .draw (draw),
    .frac (RAND_BITS'(rand_frac)),
    .cfg  (cfg),
    .pick (pick)
  );

  ils_value_ram u_ram (
    .clk     (clk),
    .wr_en   (write),
    .wr_addr (SLOT_BITS'(entry_index)),
    .wr_data (VALUE_BITS'(entry_value)),
    .rd_en   (draw && pick.fire),
    .rd_addr (pick.slot),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= draw && pick.fire;
    end else if (item_ready) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (draw && pick.fire) begin
      slot_q <= pick.slot;
    end
  end

  assign item_value = 32'(rd_data);
  assign item_slot  = 6'(slot_q);

  a_draw_gives_item: assert property (@(posedge clk) disable iff (rst)
    (draw && (walk_mode != MODE_HEAP)) |=> item_valid)
    else $error("non-heap draw gave no item");

  a_write_no_item: assert property (@(posedge clk) disable iff (rst)
    write |=> !item_valid)
    else $error("write transaction produced an item");

  a_stall_only_on_item: assert property (@(posedge clk) disable iff (rst)
    !cmd_ready |-> item_valid)
    else $error("command side stalled with no pending item");

endmodule

FILE: rtl/ils_value_ram.sv
`timescale 1ns / 1ps
// Value table: single write port, registered read port.
module ils_value_ram
  import ils_pkg::*;
(
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [SLOT_BITS-1:0]  wr_addr,
  input  logic [VALUE_BITS-1:0] wr_data,
  input  logic                  rd_en,
  input  logic [SLOT_BITS-1:0]  rd_addr,
  output logic [VALUE_BITS-1:0] rd_data
);

  logic [VALUE_BITS-1:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/ils_walker.sv
`timescale 1ns / 1ps
// Slot selection: walk pointer, swing direction and heap use marks.
module ils_walker
  import ils_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  draw,
  input  logic [RAND_BITS-1:0]  frac,
  input  walk_cfg_t             cfg,
  output pick_t                 pick
);

  localparam logic [COUNT_BITS-1:0] DEPTH_C = COUNT_BITS'(TABLE_DEPTH);
  localparam logic [COUNT_BITS-1:0] ONE_C   = COUNT_BITS'(1);

  logic [SLOT_BITS-1:0]   ptr, ptr_next;
  logic                   up, up_next;
  logic [TABLE_DEPTH-1:0] marks, marks_next;
  logic [COUNT_BITS-1:0]  total, total_next;

  logic [COUNT_BITS-1:0]           n;
  logic                            restart;
  logic [SLOT_BITS-1:0]            ptr_eff;
  logic                            up_eff;
  logic [COUNT_BITS-1:0]           ptr_inc;
  logic [RAND_BITS+COUNT_BITS-1:0] product;
  logic [SLOT_BITS-1:0]            rand_slot;
  logic                            stale;
  logic [TABLE_DEPTH-1:0]          marks_base;
  logic [COUNT_BITS-1:0]           total_base;
  logic [COUNT_BITS-1:0]           total_inc;
  logic                            hit;

  always_comb begin
    if (cfg.count == '0) begin
      n = ONE_C;
    end else if (cfg.count > DEPTH_C) begin
      n = DEPTH_C;
    end else begin
      n = cfg.count;
    end

    restart = ((cfg.mode == MODE_CYCLE) || (cfg.mode == MODE_SWING)) &&
              ({1'b0, ptr} >= n);
    ptr_eff = restart ? '0 : ptr;
    up_eff  = restart ? 1'b1 : up;
    ptr_inc = {1'b0, ptr_eff} + ONE_C;

    product   = (RAND_BITS+COUNT_BITS)'(frac) * (RAND_BITS+COUNT_BITS)'(n);
    rand_slot = SLOT_BITS'(product >> RAND_BITS);

    stale      = total >= n;
    marks_base = stale ? '0 : marks;
    total_base = stale ? '0 : total;
    total_inc  = total_base + ONE_C;
    hit        = marks_base[rand_slot];

    ptr_next   = ptr;
    up_next    = up;
    marks_next = marks;
    total_next = total;
    pick.fire  = draw;
    pick.slot  = ptr_eff;

    unique case (cfg.mode)
      MODE_CYCLE: begin
        up_next  = up_eff;
        ptr_next = (ptr_inc >= n) ? '0 : SLOT_BITS'(ptr_inc);
      end
      MODE_SWING: begin
        if (n == ONE_C) begin
          ptr_next = '0;
          up_next  = up_eff;
        end else if (up_eff) begin
          if (ptr_inc >= n) begin
            ptr_next = SLOT_BITS'(n - COUNT_BITS'(2));
            up_next  = 1'b0;
          end else begin
            ptr_next = SLOT_BITS'(ptr_inc);
            up_next  = 1'b1;
          end
        end else begin
          if (ptr_eff == '0) begin
            ptr_next = SLOT_BITS'(1);
            up_next  = 1'b1;
          end else begin
            ptr_next = ptr_eff - SLOT_BITS'(1);
            up_next  = 1'b0;
          end
        end
      end
      MODE_RANDOM: begin
        pick.slot = rand_slot;
      end
      MODE_HEAP: begin
        pick.slot  = rand_slot;
        marks_next = marks_base;
        total_next = total_base;
        if (hit) begin
          pick.fire = 1'b0;
        end else if (total_inc >= n) begin
          marks_next = '0;
          total_next = '0;
        end else begin
          marks_next[rand_slot] = 1'b1;
          total_next            = total_inc;
        end
      end
      default: begin
        pick.slot = ptr_eff;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr   <= '0;
      up    <= 1'b1;
      marks <= '0;
      total <= '0;
    end else if (draw) begin
      ptr   <= ptr_next;
      up    <= up_next;
      marks <= marks_next;
      total <= total_next;
    end
  end

endmodule
